// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define U8RX_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

`define U8RX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define U8RX_ASSERT(label, clk, rst_n, prop)

`define U8RX_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/u8rx_pkg.sv -----
package u8rx_pkg;

	localparam logic [7:0] QBT_RESET     = 8'd10;
	localparam logic [3:0] TX_FRAME_BITS = 4'd10;
	localparam logic [3:0] RX_DATA_BITS  = 4'd8;
	localparam logic [2:0] RX_Q_FIRST    = 3'd5;
	localparam logic [2:0] RX_Q_BIT      = 3'd4;
	localparam logic [2:0] RX_Q_TAIL     = 3'd2;
	localparam logic [1:0] TX_Q_LAST     = 2'd3;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_PTR_W = 1;
	localparam int IQ_CNT_W = 2;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	typedef struct packed {
		logic       rx_level;
		logic       send_request;
		logic [7:0] send_byte;
		logic       read_request;
	} in_item_t;

	typedef struct packed {
		logic       tx_level;
		logic       tx_busy;
		logic       read_valid;
		logic [7:0] read_data;
		logic [6:0] fifo_level;
		logic       rx_overflow;
		logic       rx_byte_done;
	} out_item_t;

endpackage

// ----- sv/uart_8n1_with_rx_fifo.sv -----
// 8N1 serial transceiver with a receive FIFO; each accepted transaction is one bit-timing tick
// and yields exactly one result transaction. A tick enters a two-entry input queue, is carried
// out by the transmit/receive core and leaves through a four-entry result queue, so the block
// sustains one tick per clock cycle while results are popped; with no room in the result queue
// the core stalls. The core's state update and the FIFO memory port (one write and one registered
// read a cycle) advance only on a taken tick. The FIFO memory needs no clearing pass after reset;
// quarter_bit_ticks may be written only while no transaction is queued or in flight.
`include "assert_macros.svh"

module uart_8n1_with_rx_fifo #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       push,
	output logic       full,
	input  logic       rx_level,
	input  logic       send_request,
	input  logic [7:0] send_byte,
	input  logic       read_request,
	output logic       empty,
	input  logic       pop,
	output logic       tx_level,
	output logic       tx_busy,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic [6:0] fifo_level,
	output logic       rx_overflow,
	output logic       rx_byte_done
);
	import u8rx_pkg::*;

	in_item_t  in_item;
	in_item_t  front_head;
	logic      front_valid;
	logic      room;
	logic      adv;
	logic      back_valid;
	out_item_t back_item;
	out_item_t res;

	always_comb begin
		in_item              = '0;
		in_item.rx_level     = rx_level;
		in_item.send_request = send_request;
		in_item.send_byte    = send_byte;
		in_item.read_request = read_request;
	end

	assign adv = front_valid && room;

	u8rx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (in_item),
		.valid  (front_valid),
		.head   (front_head),
		.take   (adv)
	);

	u8rx_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adv         (adv),
		.item        (front_head),
		.out_valid   (back_valid),
		.out_item    (back_item)
	);

	u8rx_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_valid),
		.item   (back_item),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (res)
	);

	assign tx_level     = res.tx_level;
	assign tx_busy      = res.tx_busy;
	assign read_valid   = res.read_valid;
	assign read_data    = res.read_data;
	assign fifo_level   = res.fifo_level;
	assign rx_overflow  = res.rx_overflow;
	assign rx_byte_done = res.rx_byte_done;

	`U8RX_ASSERT(a_idle_line_high, clk, arst_n, (empty || tx_busy || tx_level))
	`U8RX_ASSERT(a_no_data_without_pop, clk, arst_n, (empty || read_valid || (read_data == 8'd0)))
	`U8RX_ASSERT_NEXT(a_overflow_sticky, clk, arst_n, (pop && !empty && rx_overflow), (empty || rx_overflow))
	`U8RX_ASSERT_NEXT(a_core_feeds_queue, clk, arst_n, adv, back_valid)

endmodule

// ----- sv/u8rx_front.sv -----
module u8rx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8rx_pkg::in_item_t item,
	output logic               valid,
	output u8rx_pkg::in_item_t head,
	input  logic               take
);
	import u8rx_pkg::*;

	in_item_t              slot_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0]   wr_ptr_q;
	logic [IQ_PTR_W-1:0]   rd_ptr_q;
	logic [IQ_CNT_W-1:0]   count_q;
	logic                  do_push;
	logic                  do_take;

	assign full    = (count_q == IQ_CNT_W'(IQ_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_take = take && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + IQ_CNT_W'(do_push) - IQ_CNT_W'(do_take);
		end
	end

endmodule

// ----- sv/u8rx_back.sv -----
module u8rx_back #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                adv,
	input  u8rx_pkg::in_item_t  item,
	output logic                out_valid,
	output u8rx_pkg::out_item_t out_item
);
	import u8rx_pkg::*;

	localparam int IDX_W  = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	logic [7:0]        qbt_q;

	logic [9:0]        tx_shift_q, tx_shift_e, tx_shift_n;
	logic [3:0]        tx_bits_q, tx_bits_e, tx_bits_n;
	logic [1:0]        tx_qc_q, tx_qc_e, tx_qc_n;
	logic [7:0]        tx_tick_q, tx_tick_e, tx_tick_n, tx_tick_inc;
	logic              tx_start, tx_busy, tx_level, tx_qend;

	logic              rx_active_q, rx_active_n;
	logic [7:0]        rx_shift_q, rx_shift_n;
	logic [3:0]        rx_bits_q, rx_bits_n;
	logic [2:0]        rx_qc_q, rx_qc_n, rx_qc_inc, rx_target;
	logic [7:0]        rx_tick_q, rx_tick_n, rx_tick_inc;
	logic              rx_qend, rx_done;

	logic [7:0]        fifo_mem_q [FIFO_DEPTH];
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] fill_q, fill_pop, fill_n;
	logic [FILL_W+6:0] fill_ext;
	logic              ovf_q, ovf_n;
	logic              pop, fpush;

	logic              valid_s2;
	out_item_t         item_s2;
	logic [7:0]        rdata_s2;
	out_item_t         item_s1;

	always_comb begin
		tx_start    = (tx_bits_q == '0) && item.send_request;
		tx_shift_e  = tx_start ? {1'b1, item.send_byte, 1'b0} : tx_shift_q;
		tx_bits_e   = tx_start ? TX_FRAME_BITS : tx_bits_q;
		tx_qc_e     = tx_start ? 2'd0 : tx_qc_q;
		tx_tick_e   = tx_start ? 8'd0 : tx_tick_q;
		tx_busy     = (tx_bits_e != '0);
		tx_level    = tx_busy ? tx_shift_e[0] : 1'b1;
		tx_tick_inc = tx_tick_e + 8'd1;
		tx_qend     = tx_busy && (tx_tick_inc == qbt_q);
		tx_shift_n  = tx_shift_e;
		tx_bits_n   = tx_bits_e;
		tx_qc_n     = tx_qc_e;
		tx_tick_n   = tx_tick_e;
		if (tx_busy) begin
			tx_tick_n = tx_qend ? 8'd0 : tx_tick_inc;
		end
		if (tx_qend) begin
			tx_qc_n = tx_qc_e + 2'd1;
			if (tx_qc_e == TX_Q_LAST) begin
				tx_shift_n = {1'b1, tx_shift_e[9:1]};
				tx_bits_n  = tx_bits_e - 4'd1;
			end
		end
	end

	always_comb begin
		rx_active_n = rx_active_q;
		rx_shift_n  = rx_shift_q;
		rx_bits_n   = rx_bits_q;
		rx_qc_n     = rx_qc_q;
		rx_tick_n   = rx_tick_q;
		rx_done     = 1'b0;
		rx_tick_inc = rx_tick_q + 8'd1;
		rx_qend     = (rx_tick_inc == qbt_q);
		rx_qc_inc   = rx_qc_q + 3'd1;
		if (rx_bits_q == '0) begin
			rx_target = RX_Q_TAIL;
		end else if (rx_bits_q >= RX_DATA_BITS) begin
			rx_target = RX_Q_FIRST;
		end else begin
			rx_target = RX_Q_BIT;
		end
		if (!rx_active_q) begin
			if (!item.rx_level) begin
				rx_active_n = 1'b1;
				rx_bits_n   = RX_DATA_BITS;
				rx_qc_n     = 3'd0;
				rx_tick_n   = 8'd0;
				rx_shift_n  = 8'd0;
			end
		end else begin
			rx_tick_n = rx_qend ? 8'd0 : rx_tick_inc;
			if (rx_qend) begin
				if (rx_qc_inc >= rx_target) begin
					rx_qc_n = 3'd0;
					if (rx_bits_q != '0) begin
						rx_shift_n = {item.rx_level, rx_shift_q[7:1]};
						rx_bits_n  = rx_bits_q - 4'd1;
					end else begin
						rx_active_n = 1'b0;
						rx_done     = 1'b1;
					end
				end else begin
					rx_qc_n = rx_qc_inc;
				end
			end
		end
	end

	always_comb begin
		pop      = item.read_request && (fill_q != '0);
		fill_pop = fill_q - FILL_W'(pop);
		fpush    = rx_done && (fill_pop < FILL_W'(FIFO_DEPTH));
		fill_n   = fill_pop + FILL_W'(fpush);
		ovf_n    = ovf_q | (rx_done & ~fpush);
		fill_ext = {7'd0, fill_n};

		item_s1              = '0;
		item_s1.tx_level     = tx_level;
		item_s1.tx_busy      = tx_busy;
		item_s1.read_valid   = pop;
		item_s1.fifo_level   = fill_ext[6:0];
		item_s1.rx_overflow  = ovf_n;
		item_s1.rx_byte_done = rx_done;
	end

	always_ff @(posedge clk) begin
		if (adv && pop) begin
			rdata_s2 <= fifo_mem_q[head_q];
		end
		if (adv && fpush) begin
			fifo_mem_q[tail_q] <= rx_shift_q;
		end
		if (adv) begin
			item_s2 <= item_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qbt_q       <= QBT_RESET;
			tx_shift_q  <= '1;
			tx_bits_q   <= '0;
			tx_qc_q     <= '0;
			tx_tick_q   <= '0;
			rx_active_q <= 1'b0;
			rx_shift_q  <= '0;
			rx_bits_q   <= '0;
			rx_qc_q     <= '0;
			rx_tick_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				qbt_q <= cfg_wr_data;
			end
			valid_s2 <= adv;
			if (adv) begin
				tx_shift_q  <= tx_shift_n;
				tx_bits_q   <= tx_bits_n;
				tx_qc_q     <= tx_qc_n;
				tx_tick_q   <= tx_tick_n;
				rx_active_q <= rx_active_n;
				rx_shift_q  <= rx_shift_n;
				rx_bits_q   <= rx_bits_n;
				rx_qc_q     <= rx_qc_n;
				rx_tick_q   <= rx_tick_n;
				fill_q      <= fill_n;
				ovf_q       <= ovf_n;
				if (pop) begin
					head_q <= (head_q == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
				end
				if (fpush) begin
					tail_q <= (tail_q == IDX_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		out_item           = item_s2;
		out_item.read_data = item_s2.read_valid ? rdata_s2 : 8'd0;
	end

	assign out_valid = valid_s2;

endmodule

// ----- sv/u8rx_outq.sv -----
module u8rx_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8rx_pkg::out_item_t item,
	output logic                room,
	output logic                empty,
	input  logic                pop,
	output u8rx_pkg::out_item_t head
);
	import u8rx_pkg::*;

	out_item_t             slot_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic                  do_pop;

	assign empty  = (count_q == '0);
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;
	assign room   = (count_q + OQ_CNT_W'(push)) < OQ_CNT_W'(OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(do_pop);
		end
	end

endmodule

// ----- tb/uart_8n1_with_rx_fifo_test.sv -----
module uart_8n1_with_rx_fifo_test;
	import u8rx_pkg::*;

	localparam int FIFO_DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 80;
	localparam int REPORT_LIMIT = 10;
	localparam int N_OPEN = 16;

	typedef struct packed {
		in_item_t  it;
		logic      has_want;
		out_item_t want;
	} row_t;

	localparam out_item_t LINE_IDLE = '{1'b1, 1'b0, 1'b0, 8'h00, 7'h00, 1'b0, 1'b0};
	localparam out_item_t START_BIT = '{1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 1'b0, 1'b0};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       push = 1'b0;
	logic       full;
	logic       rx_level = 1'b1;
	logic       send_request = 1'b0;
	logic [7:0] send_byte = 8'h00;
	logic       read_request = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       tx_level;
	logic       tx_busy;
	logic       read_valid;
	logic [7:0] read_data;
	logic [6:0] fifo_level;
	logic       rx_overflow;
	logic       rx_byte_done;

	logic      row_has_want = 1'b0;
	out_item_t row_want = LINE_IDLE;

	// serial transceiver state as predicted
	logic [7:0] qbt_now;
	logic [7:0] rx_mem [FIFO_DEPTH];
	logic [5:0] rd_ptr;
	logic [5:0] wr_ptr;
	int         fill;
	logic       ovf;
	logic       rx_on;
	logic [7:0] rx_sr;
	logic [3:0] rx_left;
	logic [2:0] rx_q;
	logic [7:0] rx_ticks;
	logic [9:0] tx_sr;
	logic [3:0] tx_left;
	logic [1:0] tx_q;
	logic [7:0] tx_ticks;

	out_item_t results_due [$];
	out_item_t predicted;
	out_item_t want;
	out_item_t seen;

	int mismatches = 0;
	int ticks_in = 0;
	int results_out = 0;
	int bytes_done = 0;
	int reads_hit = 0;
	int peak_level = 0;
	int input_stalls = 0;
	int frames_on_line = 0;
	int baud_changes = 0;
	int quiet_cycles = 0;
	bit overflow_seen = 1'b0;
	bit hold_rx_req = 1'b0;
	bit hold_rx_done = 1'b0;
	bit steady = 1'b0;
	bit read_on_done = 1'b0;

	uart_8n1_with_rx_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push(push),
		.full(full),
		.rx_level(rx_level),
		.send_request(send_request),
		.send_byte(send_byte),
		.read_request(read_request),
		.empty(empty),
		.pop(pop),
		.tx_level(tx_level),
		.tx_busy(tx_busy),
		.read_valid(read_valid),
		.read_data(read_data),
		.fifo_level(fifo_level),
		.rx_overflow(rx_overflow),
		.rx_byte_done(rx_byte_done)
	);

	always #2 clk = ~clk;

	function automatic void uart_reset();
		qbt_now = QBT_RESET;
		rd_ptr = '0;
		wr_ptr = '0;
		fill = 0;
		ovf = 1'b0;
		rx_on = 1'b0;
		rx_sr = '0;
		rx_left = '0;
		rx_q = '0;
		rx_ticks = '0;
		tx_sr = '1;
		tx_left = '0;
		tx_q = '0;
		tx_ticks = '0;
	endfunction

	function automatic logic quarter_done(inout logic [7:0] cnt);
		logic [7:0] nxt;
		nxt = cnt + 8'd1;
		quarter_done = (nxt == qbt_now);
		cnt = quarter_done ? 8'd0 : nxt;
	endfunction

	function automatic out_item_t uart_tick(in_item_t it);
		out_item_t r;
		logic [2:0] target;
		r = '0;
		if (tx_left == 0 && it.send_request) begin
			tx_sr = {1'b1, it.send_byte, 1'b0};
			tx_left = TX_FRAME_BITS;
			tx_q = '0;
			tx_ticks = '0;
		end
		r.tx_busy = (tx_left != 0);
		r.tx_level = r.tx_busy ? tx_sr[0] : 1'b1;
		if (r.tx_busy && quarter_done(tx_ticks)) begin
			tx_q = tx_q + 2'd1;
			if (tx_q == 0) begin
				tx_sr = {1'b1, tx_sr[9:1]};
				tx_left = tx_left - 4'd1;
			end
		end

		// pop ahead of the receiver so a full FIFO read on the same tick takes the new byte
		if (it.read_request && fill > 0) begin
			r.read_valid = 1'b1;
			r.read_data = rx_mem[rd_ptr];
			rd_ptr = rd_ptr + 6'd1;
			fill--;
		end

		if (!rx_on) begin
			if (!it.rx_level) begin
				rx_on = 1'b1;
				rx_left = RX_DATA_BITS;
				rx_q = '0;
				rx_ticks = '0;
				rx_sr = '0;
			end
		end else if (quarter_done(rx_ticks)) begin
			target = (rx_left == 0) ? RX_Q_TAIL :
				(rx_left >= RX_DATA_BITS ? RX_Q_FIRST : RX_Q_BIT);
			rx_q = rx_q + 3'd1;
			if (rx_q >= target) begin
				rx_q = '0;
				if (rx_left != 0) begin
					rx_sr = {it.rx_level, rx_sr[7:1]};
					rx_left = rx_left - 4'd1;
				end else begin
					rx_on = 1'b0;
					r.rx_byte_done = 1'b1;
					if (fill < FIFO_DEPTH) begin
						rx_mem[wr_ptr] = rx_sr;
						wr_ptr = wr_ptr + 6'd1;
						fill++;
					end else begin
						ovf = 1'b1;
					end
				end
			end
		end

		r.fifo_level = fill[6:0];
		r.rx_overflow = ovf;
		return r;
	endfunction

	task automatic check_result(out_item_t w, out_item_t s);
		string bad;
		bad = "";
		if (s.tx_level !== w.tx_level) bad = {bad, " tx_level"};
		if (s.tx_busy !== w.tx_busy) bad = {bad, " tx_busy"};
		if (s.read_valid !== w.read_valid) bad = {bad, " read_valid"};
		if (s.read_data !== w.read_data) bad = {bad, " read_data"};
		if (s.fifo_level !== w.fifo_level) bad = {bad, " fifo_level"};
		if (s.rx_overflow !== w.rx_overflow) bad = {bad, " rx_overflow"};
		if (s.rx_byte_done !== w.rx_byte_done) bad = {bad, " rx_byte_done"};
		if (bad != "") begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("result %0d wrong in%s", results_out, bad);
				$display("  expected tx=%b busy=%b rv=%b rd=%h lvl=%0d ovf=%b done=%b",
					w.tx_level, w.tx_busy, w.read_valid, w.read_data, w.fifo_level,
					w.rx_overflow, w.rx_byte_done);
				$display("  got      tx=%b busy=%b rv=%b rd=%h lvl=%0d ovf=%b done=%b",
					s.tx_level, s.tx_busy, s.read_valid, s.read_data, s.fifo_level,
					s.rx_overflow, s.rx_byte_done);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && full)
				input_stalls++;
			if (push && !full) begin
				predicted = uart_tick(in_item_t'{rx_level, send_request, send_byte, read_request});
				results_due.push_back(row_has_want ? row_want : predicted);
				ticks_in++;
				bytes_done += predicted.rx_byte_done;
				reads_hit += predicted.read_valid;
				if (predicted.rx_overflow)
					overflow_seen = 1'b1;
				if (int'(predicted.fifo_level) > peak_level)
					peak_level = predicted.fifo_level;
			end
			if (pop && !empty) begin
				seen = '{tx_level, tx_busy, read_valid, read_data, fifo_level, rx_overflow,
					rx_byte_done};
				results_out++;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d arrived with nothing pending", results_out);
				end else begin
					want = results_due.pop_front();
					check_result(want, seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no transaction for %0d cycles, %0d results pending",
					quiet_cycles, results_due.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx_req && !hold_rx_done) begin
				pop <= 1'b0;
				hold_rx_done = 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			pop <= steady || ($urandom_range(99) >= 6);
		end
	end

	task automatic offer(in_item_t it, logic has_w, out_item_t w);
		if (!steady && $urandom_range(99) < 6) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_level <= it.rx_level;
		send_request <= it.send_request;
		send_byte <= it.send_byte;
		read_request <= it.read_request;
		row_has_want <= has_w;
		row_want <= w;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic tick(logic rx, int rd_pct, int sd_pct, bit force_rd);
		in_item_t it;
		it.rx_level = rx;
		it.send_request = $urandom_range(99) < sd_pct;
		it.send_byte = $urandom_range(255);
		it.read_request = force_rd || ($urandom_range(99) < rd_pct);
		offer(it, 1'b0, LINE_IDLE);
	endtask

	// drive one 8N1 frame on the rx line; some frames carry glitches or are cut short
	task automatic line_frame(logic [7:0] data, int rd_pct, int sd_pct);
		int qe;
		int kind;
		int nbits;
		int pos;
		logic lvl;
		qe = (qbt_now == 0) ? 256 : qbt_now;
		kind = read_on_done ? 0 : $urandom_range(99);
		nbits = (kind >= 92) ? $urandom_range(1, 9) : 10;
		pos = 0;
		for (int b = 0; b < nbits; b++) begin
			lvl = (b == 0) ? 1'b0 : (b == 9) ? 1'b1 : data[b - 1];
			for (int t = 0; t < 4 * qe; t++) begin
				tick((kind >= 84 && kind < 92 && $urandom_range(99) < 4) ? !lvl : lvl,
					rd_pct, sd_pct, read_on_done && pos == 35 * qe);
				pos++;
			end
		end
		repeat ($urandom_range(0, 2 * qe)) tick(1'b1, rd_pct, sd_pct, 1'b0);
		frames_on_line++;
	endtask

	task automatic random_ticks(int n, int low_pct, int rd_pct, int sd_pct);
		repeat (n) tick($urandom_range(99) >= low_pct, rd_pct, sd_pct, 1'b0);
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_quarter(logic [7:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		qbt_now = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		baud_changes++;
	endtask

	initial begin
		row_t opening [N_OPEN];
		opening = '{
			'{'{1'b1, 1'b0, 8'h00, 1'b0}, 1'b1, LINE_IDLE},
			'{'{1'b1, 1'b0, 8'hFF, 1'b1}, 1'b1, LINE_IDLE},
			'{'{1'b1, 1'b1, 8'hFF, 1'b0}, 1'b1, START_BIT},
			'{'{1'b1, 1'b1, 8'h00, 1'b1}, 1'b1, START_BIT},
			'{'{1'b0, 1'b0, 8'h00, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b0, 1'b1, 8'hAA, 1'b1}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b0, 8'h55, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b0, 1'b1, 8'hFF, 1'b1}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b1, 8'h00, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b0, 1'b0, 8'h80, 1'b1}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b0, 8'h01, 1'b1}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b1, 8'h7F, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b0, 1'b0, 8'hFE, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b1, 8'hFF, 1'b1}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b0, 8'h00, 1'b0}, 1'b0, LINE_IDLE},
			'{'{1'b1, 1'b0, 8'h00, 1'b1}, 1'b0, LINE_IDLE}
		};
		uart_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			offer(opening[i].it, opening[i].has_want, opening[i].want);

		set_quarter(8'd1);
		steady = 1'b1;
		line_frame($urandom_range(255), 30, 20);
		steady = 1'b0;

		// hold off the result side while ticks keep coming
		hold_rx_req = 1'b1;
		line_frame($urandom_range(255), 0, 25);

		// pop on the tick the byte lands
		read_on_done = 1'b1;
		line_frame($urandom_range(255) | 8'h80, 0, 25);
		read_on_done = 1'b0;

		// switch to zero quarter length while both counters are mid-frame
		set_quarter(8'd20);
		random_ticks($urandom_range(20, 39), 10, 20, 60);
		set_quarter(8'd0);
		random_ticks(256, 5, 20, 30);

		settle();
		$display("%0d ticks over %0d quarter-bit settings, %0d rx frames, %0d bytes in, %0d popped",
			ticks_in, baud_changes, frames_on_line, bytes_done, reads_hit);
		$display("FIFO peak %0d, overflow %s, input stalled %0d cycles, %0d mismatches",
			peak_level, overflow_seen ? "reached" : "not reached", input_stalls, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
